>>> rtl/core/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared widths, codes and types of the trapezoid velocity profile block.
// ----------------------------------------------------------------------------
package tvp_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned LimitWidth   = DataWidth - 1;
  localparam int unsigned TickWidth    = FracBits + 1;
  localparam int unsigned ProdWidth    = 2 * DataWidth;
  localparam int unsigned DivisorWidth = DataWidth + 2;
  localparam int unsigned RemWidth     = DataWidth + 4;
  localparam int unsigned OpWidth      = 2;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam int unsigned DispMin = ((2 ** FracBits) + 999) / 1000;
  localparam int unsigned DenEps  = (2 * (2 ** FracBits)) / 1000000;

  localparam logic [LimitWidth-1:0] MaxVelocityReset = LimitWidth'(65536);
  localparam logic [LimitWidth-1:0] MaxAccelReset    = LimitWidth'(65536);
  localparam logic [TickWidth-1:0]  TickPeriodReset  = TickWidth'(66);

  typedef enum logic [OpWidth-1:0] {
    OpTick       = 2'd0,
    OpStartSym   = 2'd1,
    OpStartTimed = 2'd2
  } op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgMaxVelocity = 2'd0,
    CfgMaxAccel    = 2'd1,
    CfgTickPeriod  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                    start;
    logic                    sqrt_mode;
    logic [ProdWidth-1:0]    dividend;
    logic [DivisorWidth-1:0] divisor;
  } unit_req_t;

  typedef struct packed {
    logic                 done;
    logic [ProdWidth-1:0] result;
  } unit_rsp_t;

endpackage

>>> rtl/core/tvp_if.sv
// ----------------------------------------------------------------------------
// tvp_if
// Handshake channels of the trapezoid velocity profile block.
// ----------------------------------------------------------------------------
interface tvp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tvp_pkg::CfgIdxWidth-1:0]     index;
  logic [tvp_pkg::DataWidth-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface tvp_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [tvp_pkg::OpWidth-1:0]         operation;
  logic signed [tvp_pkg::DataWidth-1:0] displacement;
  logic signed [tvp_pkg::DataWidth-1:0] accel_time;
  logic signed [tvp_pkg::DataWidth-1:0] cruise_time;
  logic signed [tvp_pkg::DataWidth-1:0] decel_time;
  modport source (output valid, operation, displacement, accel_time, cruise_time, decel_time,
                  input ready);
  modport sink (input valid, operation, displacement, accel_time, cruise_time, decel_time,
                output ready);
endinterface

interface tvp_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [tvp_pkg::DataWidth-1:0] velocity;
  logic signed [tvp_pkg::DataWidth-1:0] acceleration;
  logic signed [tvp_pkg::DataWidth-1:0] position;
  logic                                active;
  logic                                accepted;
  modport source (output valid, velocity, acceleration, position, active, accepted, input ready);
  modport sink (input valid, velocity, acceleration, position, active, accepted, output ready);
endinterface

>>> rtl/core/trapezoid_velocity_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_velocity_profile
// Plans three-segment motion profiles and advances them one tick per item.
// ----------------------------------------------------------------------------
// Channel  Role    Payload
// cfg_i    sink    index, data (register write)
// cmd_i    sink    operation, displacement, accel_time, cruise_time, decel_time
// rsp_o    source  velocity, acceleration, position, active, accepted
//
// A tick steps through StTkSeg, StTkVel and StTkPos, using the shared multiplier.
// A symmetric start runs one square root of 32 steps and up to three
// divisions of 64 steps each in the shared iterative unit.
// A timed start runs up to four divisions in the same iterative unit.
// Ignored starts, idle ticks and unused operations answer in the cycle after they are taken.
// Reset is asynchronous; cfg_i is always ready, cmd_i waits for the result.
module trapezoid_velocity_profile (
  input  logic        clk_i,
  input  logic        rst_ni,
  tvp_cfg_if.sink     cfg_i,
  tvp_cmd_if.sink     cmd_i,
  tvp_rsp_if.source   rsp_o
);

  localparam int unsigned Dw = tvp_pkg::DataWidth;
  localparam int unsigned Fb = tvp_pkg::FracBits;
  localparam int unsigned Lw = tvp_pkg::LimitWidth;
  localparam int unsigned Tw = tvp_pkg::TickWidth;
  localparam int unsigned Pw = tvp_pkg::ProdWidth;
  localparam int unsigned Vw = tvp_pkg::DivisorWidth;
  localparam int unsigned Sw = Dw + 3;
  localparam logic signed [Sw-1:0] PosHi = Sw'({1'b0, {(Dw-1){1'b1}}});
  localparam logic signed [Sw-1:0] PosLo = -PosHi - Sw'(1);

  typedef enum logic [3:0] {
    StIdle, StSymGo, StSymRoot, StSymTa, StSymSq, StSymDa, StSymTc,
    StTmPk, StTmQ, StTmArGo, StTmAr, StTmDr, StFinish, StTkSeg, StTkVel, StTkPos
  } state_e;

  typedef enum logic [1:0] {SegUp, SegCruise, SegDown, SegEnd} seg_e;

  function automatic logic [Dw-1:0] tadd(input logic [Dw-1:0] a, input logic [Dw-1:0] b);
    logic [Dw:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[Dw] ? '1 : s[Dw-1:0];
  endfunction

  function automatic logic [Dw-1:0] sat_time(input logic [Pw-1:0] x);
    return (|x[Pw-1:Dw]) ? '1 : x[Dw-1:0];
  endfunction

  function automatic logic [Lw-1:0] sat_rate(input logic [Pw-1:0] x);
    return (|x[Pw-1:Lw]) ? '1 : x[Lw-1:0];
  endfunction

  logic [Lw-1:0] vmax_q, amax_q;
  logic [Tw-1:0] dt_q;
  logic [Lw-1:0] vmax_eff, amax_eff;

  state_e state_q;
  seg_e   seg_q;
  logic   dirn_q, dirn_pend_q, running_q, accepted_q, out_valid_q;
  logic [Dw-1:0] elapsed_q, t1_q, t2_q, t3_q;
  logic [Lw-1:0] pk_q, ar_q, dr_q;
  logic signed [Dw-1:0] vel_q, acc_q, pos_q;
  logic [Dw-1:0] d_q, ua_q, uc_q, ud_q;
  logic [Pw-1:0] prod_q;
  tvp_pkg::unit_req_t req_q;
  tvp_pkg::unit_rsp_t rsp;

  logic [Dw-1:0] cmd_mag;
  logic          cmd_take;
  logic [Dw-1:0] mul_a, mul_b;
  logic [Pw-1:0] mul_p;
  logic [Pw-Fb-1:0] prod_hi;
  logic [Lw-1:0] capped, v_new, a_new;
  logic [Lw-1:0] root_pk;
  logic [Dw-1:0] root_val;
  logic [Vw-1:0] den2;
  logic [Pw-1:0] da2;
  logic [Dw-1:0] half;
  logic [Dw-1:0] t2_new, t3_new;
  logic [Dw:0]   step;
  logic signed [Sw-1:0] pos_sum;

  assign vmax_eff = (vmax_q == '0) ? Lw'(1) : vmax_q;
  assign amax_eff = (amax_q == '0) ? Lw'(1) : amax_q;
  assign cmd_mag  = cmd_i.displacement[Dw-1] ? Dw'(-cmd_i.displacement) : cmd_i.displacement;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = (state_q == StIdle) && (!out_valid_q || rsp_o.ready);
  assign cmd_take    = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmax_q <= tvp_pkg::MaxVelocityReset;
      amax_q <= tvp_pkg::MaxAccelReset;
      dt_q   <= tvp_pkg::TickPeriodReset;
    end else if (cfg_i.valid) begin
      case (tvp_pkg::cfg_idx_e'(cfg_i.index))
        tvp_pkg::CfgMaxVelocity: vmax_q <= cfg_i.data[Lw-1:0];
        tvp_pkg::CfgMaxAccel:    amax_q <= cfg_i.data[Lw-1:0];
        tvp_pkg::CfgTickPeriod:  dt_q   <= cfg_i.data[Tw-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StIdle: begin
        mul_a = Dw'(amax_eff);
        mul_b = cmd_mag;
      end
      StSymTa: begin
        mul_a = Dw'(pk_q);
        mul_b = Dw'(pk_q);
      end
      StTkSeg: begin
        if (elapsed_q < t1_q) begin
          mul_a = Dw'(ar_q);
          mul_b = elapsed_q;
        end else begin
          mul_a = Dw'(dr_q);
          mul_b = elapsed_q - t2_q;
        end
      end
      StTkVel: begin
        mul_a = Dw'(v_new);
        mul_b = Dw'(dt_q);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign prod_hi = prod_q[Pw-1:Fb];
  assign capped  = (prod_hi > (Pw-Fb)'(pk_q)) ? pk_q : prod_hi[Lw-1:0];

  always_comb begin
    case (seg_q)
      SegUp:     begin v_new = capped;        a_new = ar_q; end
      SegCruise: begin v_new = pk_q;          a_new = '0;   end
      SegDown:   begin v_new = pk_q - capped; a_new = dr_q; end
      default:   begin v_new = '0;            a_new = '0;   end
    endcase
  end

  assign root_val = rsp.result[Dw-1:0];
  assign root_pk  = (root_val > Dw'(vmax_eff)) ? vmax_eff : root_val[Lw-1:0];
  assign den2     = Vw'(cmd_i.accel_time[Lw-1:0]) + Vw'(cmd_i.decel_time[Lw-1:0])
                  + (cmd_i.cruise_time > 0 ? (Vw'(cmd_i.cruise_time[Lw-1:0]) << 1) : '0);
  assign da2      = {rsp.result[Pw-2:0], 1'b0};
  assign half     = Dw'(((Dw+1)'(ua_q) + (Dw+1)'(ud_q)) >> 1);
  assign t2_new   = tadd(ua_q, uc_q);
  assign t3_new   = tadd(t2_new, ud_q);
  assign step     = prod_q[Fb +: Dw+1];
  assign pos_sum  = dirn_q ? (Sw'(pos_q) - signed'(Sw'(step)))
                           : (Sw'(pos_q) + signed'(Sw'(step)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seg_q       <= SegEnd;
      dirn_q      <= 1'b0;
      dirn_pend_q <= 1'b0;
      running_q   <= 1'b0;
      accepted_q  <= 1'b0;
      out_valid_q <= 1'b0;
      elapsed_q   <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      t3_q        <= '0;
      pk_q        <= '0;
      ar_q        <= '0;
      dr_q        <= '0;
      vel_q       <= '0;
      acc_q       <= '0;
      pos_q       <= '0;
      d_q         <= '0;
      ua_q        <= '0;
      uc_q        <= '0;
      ud_q        <= '0;
      prod_q      <= '0;
      req_q       <= '0;
    end else begin
      req_q.start <= 1'b0;
      if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cmd_take) begin
            d_q         <= cmd_mag;
            dirn_pend_q <= cmd_i.displacement[Dw-1];
            case (tvp_pkg::op_e'(cmd_i.operation))
              tvp_pkg::OpTick: begin
                if (running_q) begin
                  elapsed_q <= tadd(elapsed_q, Dw'(dt_q));
                  state_q   <= StTkSeg;
                end else begin
                  vel_q       <= '0;
                  acc_q       <= '0;
                  accepted_q  <= 1'b0;
                  out_valid_q <= 1'b1;
                end
              end
              tvp_pkg::OpStartSym: begin
                if (cmd_mag < Dw'(tvp_pkg::DispMin)) begin
                  accepted_q  <= 1'b0;
                  out_valid_q <= 1'b1;
                end else begin
                  prod_q  <= mul_p;
                  ar_q    <= amax_eff;
                  dr_q    <= amax_eff;
                  state_q <= StSymGo;
                end
              end
              tvp_pkg::OpStartTimed: begin
                if (cmd_mag < Dw'(tvp_pkg::DispMin) || cmd_i.accel_time <= 0 ||
                    cmd_i.decel_time <= 0) begin
                  accepted_q  <= 1'b0;
                  out_valid_q <= 1'b1;
                end else begin
                  ua_q <= Dw'(cmd_i.accel_time[Lw-1:0]);
                  ud_q <= Dw'(cmd_i.decel_time[Lw-1:0]);
                  uc_q <= (cmd_i.cruise_time > 0) ? Dw'(cmd_i.cruise_time[Lw-1:0]) : '0;
                  if (den2 > Vw'(tvp_pkg::DenEps)) begin
                    req_q.start     <= 1'b1;
                    req_q.sqrt_mode <= 1'b0;
                    req_q.dividend  <= Pw'(cmd_mag) << (Fb + 1);
                    req_q.divisor   <= den2;
                    state_q         <= StTmPk;
                  end else begin
                    pk_q    <= '0;
                    state_q <= StTmArGo;
                  end
                end
              end
              default: begin
                accepted_q  <= 1'b0;
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        StSymGo: begin
          req_q.start     <= 1'b1;
          req_q.sqrt_mode <= 1'b1;
          req_q.dividend  <= prod_q;
          req_q.divisor   <= '0;
          state_q         <= StSymRoot;
        end
        StSymRoot: begin
          if (rsp.done) begin
            pk_q            <= root_pk;
            req_q.start     <= 1'b1;
            req_q.sqrt_mode <= 1'b0;
            req_q.dividend  <= Pw'(root_pk) << Fb;
            req_q.divisor   <= Vw'(amax_eff);
            state_q         <= StSymTa;
          end
        end
        StSymTa: begin
          if (rsp.done) begin
            ua_q    <= sat_time(rsp.result);
            ud_q    <= sat_time(rsp.result);
            prod_q  <= mul_p;
            state_q <= StSymSq;
          end
        end
        StSymSq: begin
          req_q.start     <= 1'b1;
          req_q.sqrt_mode <= 1'b0;
          req_q.dividend  <= prod_q;
          req_q.divisor   <= Vw'({amax_eff, 1'b0});
          state_q         <= StSymDa;
        end
        StSymDa: begin
          if (rsp.done) begin
            if (Pw'(d_q) > da2) begin
              req_q.start     <= 1'b1;
              req_q.sqrt_mode <= 1'b0;
              req_q.dividend  <= Pw'(d_q - da2[Dw-1:0]) << Fb;
              req_q.divisor   <= Vw'(pk_q);
              state_q         <= StSymTc;
            end else begin
              uc_q    <= '0;
              state_q <= StFinish;
            end
          end
        end
        StSymTc: begin
          if (rsp.done) begin
            uc_q    <= sat_time(rsp.result);
            state_q <= StFinish;
          end
        end
        StTmPk: begin
          if (rsp.done) begin
            if (rsp.result > Pw'(vmax_eff)) begin
              pk_q            <= vmax_eff;
              req_q.start     <= 1'b1;
              req_q.sqrt_mode <= 1'b0;
              req_q.dividend  <= Pw'(d_q) << Fb;
              req_q.divisor   <= Vw'(vmax_eff);
              state_q         <= StTmQ;
            end else begin
              pk_q    <= rsp.result[Lw-1:0];
              state_q <= StTmArGo;
            end
          end
        end
        StTmQ: begin
          if (rsp.done) begin
            uc_q    <= (rsp.result > Pw'(half)) ? sat_time(rsp.result - Pw'(half)) : '0;
            state_q <= StTmArGo;
          end
        end
        StTmArGo: begin
          req_q.start     <= 1'b1;
          req_q.sqrt_mode <= 1'b0;
          req_q.dividend  <= Pw'(pk_q) << Fb;
          req_q.divisor   <= Vw'(ua_q);
          state_q         <= StTmAr;
        end
        StTmAr: begin
          if (rsp.done) begin
            ar_q            <= sat_rate(rsp.result);
            req_q.start     <= 1'b1;
            req_q.sqrt_mode <= 1'b0;
            req_q.dividend  <= Pw'(pk_q) << Fb;
            req_q.divisor   <= Vw'(ud_q);
            state_q         <= StTmDr;
          end
        end
        StTmDr: begin
          if (rsp.done) begin
            dr_q    <= sat_rate(rsp.result);
            state_q <= StFinish;
          end
        end
        StFinish: begin
          dirn_q      <= dirn_pend_q;
          elapsed_q   <= '0;
          vel_q       <= '0;
          acc_q       <= '0;
          pos_q       <= '0;
          t1_q        <= ua_q;
          t2_q        <= t2_new;
          t3_q        <= t3_new;
          running_q   <= 1'b1;
          accepted_q  <= 1'b1;
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        StTkSeg: begin
          if (elapsed_q < t1_q) begin
            seg_q <= SegUp;
          end else if (elapsed_q < t2_q) begin
            seg_q <= SegCruise;
          end else if (elapsed_q < t3_q) begin
            seg_q <= SegDown;
          end else begin
            seg_q <= SegEnd;
          end
          prod_q  <= mul_p;
          state_q <= StTkVel;
        end
        StTkVel: begin
          vel_q <= dirn_q ? -signed'(Dw'(v_new)) : signed'(Dw'(v_new));
          acc_q <= ((seg_q == SegDown) ^ dirn_q) ? -signed'(Dw'(a_new)) : signed'(Dw'(a_new));
          if (seg_q == SegEnd) begin
            running_q <= 1'b0;
          end
          prod_q  <= mul_p;
          state_q <= StTkPos;
        end
        StTkPos: begin
          if (pos_sum > PosHi) begin
            pos_q <= PosHi[Dw-1:0];
          end else if (pos_sum < PosLo) begin
            pos_q <= PosLo[Dw-1:0];
          end else begin
            pos_q <= pos_sum[Dw-1:0];
          end
          accepted_q  <= 1'b0;
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  tvp_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.velocity     = vel_q;
  assign rsp_o.acceleration = acc_q;
  assign rsp_o.position     = pos_q;
  assign rsp_o.active       = running_q;
  assign rsp_o.accepted     = accepted_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> (!out_valid_q || rsp_o.ready))
    else $error("New item taken while a result was still held.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && accepted_q) |-> running_q)
    else $error("Accepted start reported without a running profile.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (vel_q == '0))
    else $error("Nonzero velocity while idle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_q.start |-> (state_q != StIdle))
    else $error("Arithmetic unit started outside a planning step.");

endmodule

>>> rtl/core/tvp_iter_unit.sv
// ----------------------------------------------------------------------------
// tvp_iter_unit
// Iterative divide and square root sharing one compare and subtract stage.
// ----------------------------------------------------------------------------
module tvp_iter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tvp_pkg::unit_req_t  req_i,
  output tvp_pkg::unit_rsp_t  rsp_o
);

  localparam int unsigned Pw  = tvp_pkg::ProdWidth;
  localparam int unsigned Dw  = tvp_pkg::DataWidth;
  localparam int unsigned Rw  = tvp_pkg::RemWidth;
  localparam int unsigned Vw  = tvp_pkg::DivisorWidth;
  localparam int unsigned Cw  = $clog2(Pw + 1);

  logic          busy_q;
  logic          done_q;
  logic          mode_q;
  logic [Cw-1:0] cnt_q;
  logic [Pw-1:0] x_q;
  logic [Rw-1:0] rem_q;
  logic [Dw-1:0] root_q;
  logic [Vw-1:0] dvs_q;
  logic [Rw-1:0] cand;
  logic [Rw-1:0] subtrahend;
  logic [Rw-1:0] diff;
  logic          ge;

  always_comb begin
    if (mode_q) begin
      cand       = {rem_q[Rw-3:0], x_q[Pw-1 -: 2]};
      subtrahend = Rw'({root_q, 2'b01});
    end else begin
      cand       = {rem_q[Rw-2:0], x_q[Pw-1]};
      subtrahend = Rw'(dvs_q);
    end
    ge   = cand >= subtrahend;
    diff = cand - subtrahend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        mode_q <= req_i.sqrt_mode;
        cnt_q  <= req_i.sqrt_mode ? Cw'(Pw / 2 - 1) : Cw'(Pw - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= req_i.dividend;
      dvs_q  <= req_i.divisor;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff : cand;
      if (mode_q) begin
        x_q    <= {x_q[Pw-3:0], 2'b00};
        root_q <= {root_q[Dw-2:0], ge};
      end else begin
        x_q <= {x_q[Pw-2:0], ge};
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = mode_q ? Pw'(root_q) : x_q;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the trapezoid velocity profile block against an in-bench predictor.
// A directed table covers ignored starts, extremes and restarts; random
// profiles with random tick runs follow under several limit settings, with
// bursty command traffic and a result side that stalls, once for very long.
// ----------------------------------------------------------------------------
module testbench;
  import tvp_pkg::*;

  localparam logic [OpWidth-1:0] OpUnused = 2'd3;
  localparam int unsigned IdleLimit = 20000;
  localparam logic [63:0] TimeMax = 64'hFFFF_FFFF;
  localparam logic [63:0] SignedMax = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [OpWidth-1:0]          op;
    logic signed [DataWidth-1:0] disp;
    logic signed [DataWidth-1:0] t_up;
    logic signed [DataWidth-1:0] t_coast;
    logic signed [DataWidth-1:0] t_down;
  } motion_cmd_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] velocity;
    logic signed [DataWidth-1:0] acceleration;
    logic signed [DataWidth-1:0] position;
    logic                        active;
    logic                        accepted;
  } motion_state_t;

  typedef struct packed {
    motion_cmd_t   cmd;
    logic          known;
    motion_state_t want;
  } directed_row_t;

  logic clk;
  logic rst_n;

  tvp_cfg_if cfg ();
  tvp_cmd_if cmd ();
  tvp_rsp_if rsp ();

  trapezoid_velocity_profile dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg),
    .cmd_i (cmd),
    .rsp_o (rsp)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor state.
  logic [63:0] lim_vel, lim_acc, dt_step;
  logic        dir_neg, moving;
  logic [63:0] t_elapsed, v_peak, rate_up, rate_down;
  logic [63:0] t_ramp_end, t_coast_end, t_move_end;
  longint      vel_now, acc_now, pos_now;

  motion_state_t expected_motion[$];
  int unsigned   failures = 0;
  int unsigned   results_seen = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   burst_left;

  function automatic logic [63:0] umin(logic [63:0] a, logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [63:0] time_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] x, y;
    x = umin(a, TimeMax);
    y = umin(b, TimeMax);
    return (x > TimeMax - y) ? TimeMax : x + y;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] scale_capped(logic [63:0] a, logic [63:0] t,
                                               logic [63:0] cap);
    logic [127:0] p;
    p = (128'(a) * 128'(t)) >> FracBits;
    return (p > 128'(cap)) ? cap : p[63:0];
  endfunction

  task automatic launch(input longint disp);
    dir_neg   = disp < 0;
    t_elapsed = 0;
    vel_now   = 0;
    acc_now   = 0;
    pos_now   = 0;
  endtask

  task automatic advance_tick();
    logic [63:0] t, v, a, step;
    logic        neg_a;
    neg_a = 1'b0;
    if (!moving) begin
      vel_now = 0;
      acc_now = 0;
      return;
    end
    t_elapsed = time_add(t_elapsed, dt_step);
    t = t_elapsed;
    if (t < t_ramp_end) begin
      a = rate_up;
      v = scale_capped(rate_up, t, v_peak);
    end else if (t < t_coast_end) begin
      a = 0;
      v = v_peak;
    end else if (t < t_move_end) begin
      a = rate_down;
      neg_a = 1'b1;
      v = v_peak - scale_capped(rate_down, t - t_coast_end, v_peak);
    end else begin
      a = 0;
      v = 0;
      moving = 1'b0;
    end
    if (dir_neg) neg_a = !neg_a;
    vel_now = dir_neg ? -longint'(v) : longint'(v);
    acc_now = neg_a ? -longint'(a) : longint'(a);
    step = (v * dt_step) >> FracBits;
    if (dir_neg) begin
      pos_now = pos_now - longint'(step);
      if (pos_now < -longint'(SignedMax) - 1) pos_now = -longint'(SignedMax) - 1;
    end else begin
      pos_now = pos_now + longint'(step);
      if (pos_now > longint'(SignedMax)) pos_now = longint'(SignedMax);
    end
  endtask

  task automatic predict_motion(input motion_cmd_t c, output motion_state_t r);
    longint      disp;
    logic [63:0] d, vmax, amax, pk, ta, da, tc, ua, uc, ud, den2, q, half;
    logic        took;
    took = 1'b0;
    disp = longint'(c.disp);
    d    = (disp < 0) ? 64'(-disp) : 64'(disp);
    vmax = (lim_vel == 0) ? 64'd1 : lim_vel;
    amax = (lim_acc == 0) ? 64'd1 : lim_acc;
    case (c.op)
      OpTick: advance_tick();
      OpStartSym: begin
        if (d >= DispMin) begin
          took = 1'b1;
          launch(disp);
          pk = umin(int_sqrt(amax * d), vmax);
          ta = (pk << FracBits) / amax;
          da = (pk * pk) / (2 * amax);
          tc = (d > 2 * da) ? ((d - 2 * da) << FracBits) / pk : 64'd0;
          v_peak      = pk;
          rate_up     = amax;
          rate_down   = amax;
          t_ramp_end  = umin(ta, TimeMax);
          t_coast_end = time_add(t_ramp_end, tc);
          t_move_end  = time_add(t_coast_end, ta);
          moving      = 1'b1;
        end
      end
      OpStartTimed: begin
        if (d >= DispMin && c.t_up > 0 && c.t_down > 0) begin
          took = 1'b1;
          launch(disp);
          ua = 64'(c.t_up);
          ud = 64'(c.t_down);
          uc = (c.t_coast > 0) ? 64'(c.t_coast) : 64'd0;
          den2 = ua + 2 * uc + ud;
          pk = (den2 > DenEps) ? (d << (FracBits + 1)) / den2 : 64'd0;
          if (pk > vmax) begin
            q    = (d << FracBits) / vmax;
            half = (ua + ud) >> 1;
            pk   = vmax;
            uc   = (q > half) ? q - half : 64'd0;
          end
          v_peak      = pk;
          rate_up     = umin((pk << FracBits) / ua, SignedMax);
          rate_down   = umin((pk << FracBits) / ud, SignedMax);
          t_ramp_end  = umin(ua, TimeMax);
          t_coast_end = time_add(t_ramp_end, uc);
          t_move_end  = time_add(t_coast_end, ud);
          moving      = 1'b1;
        end
      end
      default: ;
    endcase
    r.velocity     = vel_now[31:0];
    r.acceleration = acc_now[31:0];
    r.position     = pos_now[31:0];
    r.active       = moving;
    r.accepted     = took;
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CfgMaxVelocity: lim_vel = 64'(value[30:0]);
      CfgMaxAccel:    lim_acc = 64'(value[30:0]);
      CfgTickPeriod:  dt_step = 64'(value[16:0]);
      default: ;
    endcase
  endtask

  task automatic apply_limits(input logic [31:0] v, input logic [31:0] a,
                              input logic [31:0] t);
    cmd.valid <= 1'b0;
    wait (expected_motion.size() == 0);
    @(posedge clk);
    write_register(CfgMaxVelocity, v);
    write_register(CfgMaxAccel, a);
    write_register(CfgTickPeriod, t);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_command(input motion_cmd_t c, input logic known,
                              input motion_state_t want);
    motion_state_t r;
    cmd.valid        <= 1'b1;
    cmd.operation    <= c.op;
    cmd.displacement <= c.disp;
    cmd.accel_time   <= c.t_up;
    cmd.cruise_time  <= c.t_coast;
    cmd.decel_time   <= c.t_down;
    do @(posedge clk); while (!cmd.ready);
    predict_motion(c, r);
    expected_motion.push_back(known ? want : r);
    if (burst_left == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [31:0] rand_width(int unsigned lo, int unsigned hi);
    int unsigned w;
    logic [31:0] m;
    w = $urandom_range(lo, hi);
    m = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
    return $urandom & m;
  endfunction

  task automatic random_phase(input int unsigned count);
    motion_cmd_t   c;
    motion_state_t none;
    int unsigned   sent, n, kind;
    sent = 0;
    none = '0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      c = '0;
      if (kind < 8) begin
        c.op   = ($urandom_range(0, 1) != 0) ? OpStartSym : OpStartTimed;
        c.disp = rand_width(7, 22);
        if ($urandom_range(0, 1) != 0) c.disp = -c.disp;
        c.t_up    = rand_width(10, 19);
        c.t_coast = ($urandom_range(0, 5) == 0) ? -rand_width(1, 31) : rand_width(0, 19);
        c.t_down  = rand_width(10, 19);
        send_command(c, 1'b0, none);
        n = $urandom_range(1, 70);
        sent += 1 + n;
        c.op = OpTick;
        repeat (n) send_command(c, 1'b0, none);
      end else if (kind == 8) begin
        c = {$urandom, $urandom, $urandom, $urandom, $urandom};
        send_command(c, 1'b0, none);
        sent++;
      end else begin
        n = $urandom_range(1, 5);
        sent += n;
        c.op = OpTick;
        repeat (n) send_command(c, 1'b0, none);
      end
    end
  endtask

  // Result side: changing stall patterns and one long hold-off.
  int unsigned stall_mode, mode_cycles, hold_left;
  logic        hold_done;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp.ready   <= 1'b0;
      stall_mode  <= 0;
      mode_cycles <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 400) begin
      rsp.ready <= 1'b0;
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode  <= $urandom_range(0, 2);
        mode_cycles <= $urandom_range(20, 200);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
        0:       rsp.ready <= 1'b1;
        1:       rsp.ready <= ($urandom_range(0, 1) != 0);
        default: rsp.ready <= (mode_cycles % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    motion_state_t w;
    if (rst_n && rsp.valid && rsp.ready) begin
      results_seen <= results_seen + 1;
      if (expected_motion.size() == 0) begin
        $error("unexpected item: velocity %0d position %0d", rsp.velocity, rsp.position);
        failures++;
      end else begin
        w = expected_motion.pop_front();
        if (rsp.velocity !== w.velocity) begin
          $error("velocity: expected %0d, got %0d", w.velocity, rsp.velocity);
          failures++;
        end
        if (rsp.acceleration !== w.acceleration) begin
          $error("acceleration: expected %0d, got %0d", w.acceleration, rsp.acceleration);
          failures++;
        end
        if (rsp.position !== w.position) begin
          $error("position: expected %0d, got %0d", w.position, rsp.position);
          failures++;
        end
        if (rsp.active !== w.active) begin
          $error("active: expected %0b, got %0b", w.active, rsp.active);
          failures++;
        end
        if (rsp.accepted !== w.accepted) begin
          $error("accepted: expected %0b, got %0b", w.accepted, rsp.accepted);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)
        || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  directed_row_t directed[21];

  initial begin
    motion_state_t zero;
    zero         = '0;
    burst_left   = 0;
    lim_vel      = 64'(MaxVelocityReset);
    lim_acc      = 64'(MaxAccelReset);
    dt_step      = 64'(TickPeriodReset);
    dir_neg      = 1'b0;
    moving       = 1'b0;
    t_elapsed    = 0;
    v_peak       = 0;
    rate_up      = 0;
    rate_down    = 0;
    t_ramp_end   = 0;
    t_coast_end  = 0;
    t_move_end   = 0;
    vel_now      = 0;
    acc_now      = 0;
    pos_now      = 0;
    rst_n            <= 1'b0;
    cfg.valid        <= 1'b0;
    cfg.index        <= CfgMaxVelocity;
    cfg.data         <= '0;
    cmd.valid        <= 1'b0;
    cmd.operation    <= OpTick;
    cmd.displacement <= '0;
    cmd.accel_time   <= '0;
    cmd.cruise_time  <= '0;
    cmd.decel_time   <= '0;

    directed = '{
      '{'{OpTick, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, zero},
      '{'{OpUnused, 32'sd5000, 32'sd1, 32'sd1, 32'sd1}, 1'b1, zero},
      '{'{OpStartSym, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, zero},
      '{'{OpStartSym, 32'(DispMin - 1), 32'sd0, 32'sd0, 32'sd0}, 1'b1, zero},
      '{'{OpStartTimed, 32'sd65536, 32'sd0, 32'sd0, 32'sd65536}, 1'b1, zero},
      '{'{OpStartTimed, 32'sd65536, 32'sd65536, 32'sd0, -32'sd1}, 1'b1, zero},
      '{'{OpStartTimed, 32'sd65536, 32'h8000_0000, 32'sd0, 32'sd65536}, 1'b1, zero},
      '{'{OpStartSym, 32'(DispMin), 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero},
      '{'{OpTick, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero},
      '{'{OpTick, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero},
      '{'{OpStartSym, 32'h8000_0000, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero},
      '{'{OpTick, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero},
      '{'{OpStartSym, 32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero},
      '{'{OpTick, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero},
      '{'{OpStartTimed, -32'sd196608, 32'sd65536, -32'sd5, 32'sd65536}, 1'b0, zero},
      '{'{OpTick, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero},
      '{'{OpStartTimed, 32'h7FFF_FFFF, 32'sd1, 32'h7FFF_FFFF, 32'sd1}, 1'b0, zero},
      '{'{OpTick, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero},
      '{'{OpStartTimed, 32'sd65536, 32'h7FFF_FFFF, 32'sd0, 32'h7FFF_FFFF}, 1'b0, zero},
      '{'{OpTick, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero},
      '{'{OpUnused, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, zero}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_command(directed[i].cmd, directed[i].known, directed[i].want);

    apply_limits(32'd262144, 32'd524288, 32'd16384);
    random_phase(220);
    apply_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65536);
    random_phase(200);
    apply_limits(32'd0, 32'd0, 32'd0);
    random_phase(100);
    apply_limits(32'd1, 32'd1, 32'd1);
    random_phase(100);
    apply_limits(32'd131072, 32'd65536, 32'd32768);
    random_phase(220);
    apply_limits(32'hFFFF_FFFF, 32'd1000, 32'd8192);
    random_phase(150);

    cmd.valid <= 1'b0;
    wait (expected_motion.size() == 0);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tvp_pkg.sv
rtl/core/tvp_if.sv
rtl/core/tvp_iter_unit.sv
rtl/core/trapezoid_velocity_profile.sv
test/testbench.sv
